// ----- src/kml_pkg.sv -----
`default_nettype none
package kml_pkg;

  localparam int unsigned MAX_POINTS_DEF  = 1024;
  localparam int unsigned MAX_CENTERS_DEF = 16;
  localparam int unsigned MAX_DIMS_DEF    = 4;
  localparam int unsigned COORD_BITS_DEF  = 24;

  localparam int unsigned MODE_W   = 3;
  localparam int unsigned PIDX_W   = 10;
  localparam int unsigned DIDX_W   = 2;
  localparam int unsigned VALUE_W  = 24;
  localparam int unsigned LAB_W    = 4;
  localparam int unsigned COUNT_W  = 11;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 11;

  localparam int unsigned NCENT_W = 5;
  localparam int unsigned NITER_W = 8;
  localparam int unsigned NPTS_W  = 11;
  localparam int unsigned NDIMS_W = 3;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD_COORD = 3'd0,
    MODE_LOAD_LABEL = 3'd1,
    MODE_RUN        = 3'd2,
    MODE_READ_POINT = 3'd3,
    MODE_READ_CENTER = 3'd4
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_CENTERS    = 2'd0,
    CFG_NUM_ITERATIONS = 2'd1,
    CFG_NUM_POINTS     = 2'd2,
    CFG_DIMS_IN_USE    = 2'd3
  } cfg_idx_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_RD_PT1, ST_RD_PT2, ST_RD_CT,
    ST_CLR, ST_ACC_L, ST_ACC_LW, ST_ACC_R, ST_ACC_W, ST_CNT_R, ST_CNT_W,
    ST_DIV_R, ST_DIV_S, ST_DIV_W,
    ST_AS_RD, ST_AS_DIF, ST_AS_SQ, ST_AS_ACC,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic [MODE_W-1:0]        mode;
    logic [PIDX_W-1:0]        point_index;
    logic [DIDX_W-1:0]        dim_index;
    logic signed [VALUE_W-1:0] value;
    logic [LAB_W-1:0]         label_or_center;
  } in_item_t;

  typedef struct packed {
    logic [LAB_W-1:0]          label;
    logic signed [VALUE_W-1:0] coord_out;
    logic [COUNT_W-1:0]        member_count;
    logic                      done_res;
  } out_item_t;

endpackage
`default_nettype wire

// ----- src/kml_ram.sv -----
`default_nettype none
module kml_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

// ----- src/kml_div.sv -----
`default_nettype none
module kml_div #(
  parameter int unsigned SUM_W = 34,
  parameter int unsigned CNT_W = 11
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  input  wire logic signed [SUM_W-1:0] dividend_i,
  input  wire logic [CNT_W-1:0]        divisor_i,
  output      logic                    done_o,
  output      logic signed [SUM_W-1:0] quotient_o
);

  localparam int unsigned STEP_W = $clog2(SUM_W + 1);

  logic              busy_q, busy_d, done_q, done_d, neg_q, neg_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [CNT_W-1:0]  rem_q, rem_d, div_q, div_d;
  logic [SUM_W-1:0]  quo_q, quo_d;
  logic [CNT_W:0]    trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    neg_d  = neg_q;
    step_d = step_q;
    rem_d  = rem_q;
    div_d  = div_q;
    quo_d  = quo_q;
    trial  = {rem_q, quo_q[SUM_W-1]};
    if (start_i) begin
      busy_d = 1'b1;
      neg_d  = dividend_i[SUM_W-1];
      quo_d  = dividend_i[SUM_W-1] ? SUM_W'(-dividend_i) : SUM_W'(dividend_i);
      rem_d  = '0;
      div_d  = divisor_i;
      step_d = STEP_W'(SUM_W);
    end else if (busy_q) begin
      if (trial >= {1'b0, div_q}) begin
        rem_d = CNT_W'(trial - {1'b0, div_q});
        quo_d = {quo_q[SUM_W-2:0], 1'b1};
      end else begin
        rem_d = trial[CNT_W-1:0];
        quo_d = {quo_q[SUM_W-2:0], 1'b0};
      end
      step_d = step_q - 1'b1;
      if (step_q == STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    rem_q <= rem_d;
    div_q <= div_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? -signed'(quo_q) : signed'(quo_q);

endmodule
`default_nettype wire

// ----- src/kmeans_lloyd_clustering.sv -----
`default_nettype none
// Lloyd k-means engine. Load-coordinate and load-label items are accepted in ST_IDLE and can
// follow back to back unless the output is stalled; a center read goes through ST_RD_CT and a
// point read through ST_RD_PT1 and ST_RD_PT2 (label memory, then center memory). A run item
// holds the input stalled until done: each center update clears the MAX_CENTERS*MAX_DIMS sum
// entries, accumulates every point, then visits each center coordinate and runs the bit-serial
// divider for each non-empty one; each iteration adds an assignment pass over all points and
// centers (one coordinate pair per memory read). Center reads before the first run return zero.
module kmeans_lloyd_clustering
  import kml_pkg::*;
#(
  parameter int unsigned MAX_POINTS  = MAX_POINTS_DEF,
  parameter int unsigned MAX_CENTERS = MAX_CENTERS_DEF,
  parameter int unsigned MAX_DIMS    = MAX_DIMS_DEF,
  parameter int unsigned COORD_BITS  = COORD_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output      logic                  in_stall_o,
  input  wire in_item_t              in_item_i,
  output      logic                  out_valid_o,
  input  wire logic                  out_stall_i,
  output      out_item_t             out_item_o,
  input  wire logic                  cfg_valid_i,
  output      logic                  cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned PA_W  = $clog2(MAX_POINTS * MAX_DIMS);
  localparam int unsigned PT_W  = $clog2(MAX_POINTS);
  localparam int unsigned CA_W  = $clog2(MAX_CENTERS * MAX_DIMS);
  localparam int unsigned LBL_W = $clog2(MAX_CENTERS);
  localparam int unsigned LS_W  = (LBL_W > LAB_W) ? LBL_W : LAB_W;
  localparam int unsigned NW    = $clog2(MAX_POINTS + 1);
  localparam int unsigned KW    = $clog2(MAX_CENTERS + 1);
  localparam int unsigned DW    = $clog2(MAX_DIMS + 1);
  localparam int unsigned CIW   = $clog2(MAX_CENTERS * MAX_DIMS + 1);
  localparam int unsigned CNT_W = NW;
  localparam int unsigned SUM_W = COORD_BITS + NW;
  localparam int unsigned DF_W  = COORD_BITS + 1;
  localparam int unsigned SQ_W  = 2 * DF_W;
  localparam int unsigned DIST_W = SQ_W + DW;
  localparam logic [PA_W-1:0] PMD = PA_W'(MAX_DIMS);
  localparam logic [CA_W-1:0] CMD = CA_W'(MAX_DIMS);
  localparam logic [CIW-1:0]  CLR_LAST = CIW'(MAX_CENTERS * MAX_DIMS - 1);

  state_e state_q, state_d;

  logic [NCENT_W-1:0] ncent_q, ncent_d;
  logic [NITER_W-1:0] niter_q, niter_d;
  logic [NPTS_W-1:0]  npts_q, npts_d;
  logic [NDIMS_W-1:0] ndims_q, ndims_d;
  logic [KW-1:0] k_use;
  logic [NW-1:0] n_use;
  logic [DW-1:0] d_use;

  logic [NW-1:0]     p_q, p_d;
  logic [DW-1:0]     j_q, j_d;
  logic [LBL_W-1:0]  c_q, c_d;
  logic [CIW-1:0]    idx_q, idx_d;
  logic [NITER_W-1:0] it_q, it_d;
  logic [LBL_W-1:0]  lbl_q, lbl_d, best_c_q, best_c_d;
  logic [DIST_W-1:0] acc_q, acc_d, best_q, best_d, acc_new;
  logic signed [DF_W-1:0] diff_q, diff_d;
  logic [SQ_W-1:0]   sq_q, sq_d;
  logic              ran_q, ran_d;
  logic [DIDX_W-1:0] rd_di_q, rd_di_d;
  logic              rd_pok_q, rd_pok_d, rd_dok_q, rd_dok_d, rd_cok_q, rd_cok_d;

  logic      out_valid_q, out_valid_d;
  out_item_t out_q, out_d;

  logic                  pc_we;
  logic [PA_W-1:0]       pc_waddr, pc_raddr;
  logic [COORD_BITS-1:0] pc_wdata, pc_rdata;
  logic                  lb_we;
  logic [PT_W-1:0]       lb_waddr, lb_raddr;
  logic [LS_W-1:0]       lb_wdata, lb_rdata;
  logic                  ct_we;
  logic [CA_W-1:0]       ct_waddr, ct_raddr;
  logic [COORD_BITS-1:0] ct_wdata, ct_rdata;
  logic                  sm_we;
  logic [CA_W-1:0]       sm_waddr, sm_raddr;
  logic [SUM_W-1:0]      sm_wdata, sm_rdata;
  logic                  cn_we;
  logic [LBL_W-1:0]      cn_waddr, cn_raddr;
  logic [CNT_W-1:0]      cn_wdata, cn_rdata;

  logic                    div_start, div_done;
  logic signed [SUM_W-1:0] div_q;

  logic accept, pt_ok, dim_ok, ctr_ok;
  logic [LBL_W-1:0] lbl_clamped;
  logic [PA_W-1:0]  pc_pj;
  logic [CA_W-1:0]  ct_cj, sm_lj;

  always_comb begin
    if (ncent_q == '0) k_use = KW'(1);
    else if (32'(ncent_q) > MAX_CENTERS) k_use = KW'(MAX_CENTERS);
    else k_use = KW'(ncent_q);
    if (npts_q == '0) n_use = NW'(1);
    else if (32'(npts_q) > MAX_POINTS) n_use = NW'(MAX_POINTS);
    else n_use = NW'(npts_q);
    if (ndims_q == '0) d_use = DW'(1);
    else if (32'(ndims_q) > MAX_DIMS) d_use = DW'(MAX_DIMS);
    else d_use = DW'(ndims_q);
  end

  assign cfg_ready_o = 1'b1;

  always_comb begin
    ncent_d = ncent_q;
    niter_d = niter_q;
    npts_d  = npts_q;
    ndims_d = ndims_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_NUM_CENTERS:    ncent_d = cfg_data_i[NCENT_W-1:0];
        CFG_NUM_ITERATIONS: niter_d = cfg_data_i[NITER_W-1:0];
        CFG_NUM_POINTS:     npts_d  = cfg_data_i[NPTS_W-1:0];
        CFG_DIMS_IN_USE:    ndims_d = cfg_data_i[NDIMS_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall_o = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;
  assign pt_ok  = 32'(in_item_i.point_index) < MAX_POINTS;
  assign dim_ok = 32'(in_item_i.dim_index) < MAX_DIMS;
  assign ctr_ok = 32'(in_item_i.label_or_center) < MAX_CENTERS;

  always_comb begin
    if (32'(lb_rdata) > 32'(k_use) - 32'd1) lbl_clamped = LBL_W'(k_use - 1'b1);
    else lbl_clamped = LBL_W'(lb_rdata);
  end

  assign pc_pj   = PA_W'(PA_W'(p_q) * PMD + PA_W'(j_q));
  assign ct_cj   = CA_W'(CA_W'(c_q) * CMD + CA_W'(j_q));
  assign sm_lj   = CA_W'(CA_W'(lbl_q) * CMD + CA_W'(j_q));
  assign acc_new = acc_q + DIST_W'(sq_q);

  always_comb begin
    state_d = state_q;
    p_d = p_q; j_d = j_q; c_d = c_q; idx_d = idx_q; it_d = it_q;
    lbl_d = lbl_q; best_c_d = best_c_q; acc_d = acc_q; best_d = best_q;
    diff_d = diff_q; sq_d = sq_q; ran_d = ran_q;
    rd_di_d = rd_di_q; rd_pok_d = rd_pok_q; rd_dok_d = rd_dok_q; rd_cok_d = rd_cok_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d = out_q;
    pc_we = 1'b0; pc_waddr = pc_pj; pc_wdata = '0; pc_raddr = pc_pj;
    lb_we = 1'b0; lb_waddr = PT_W'(p_q); lb_wdata = '0; lb_raddr = PT_W'(p_q);
    ct_we = 1'b0; ct_waddr = ct_cj; ct_wdata = '0; ct_raddr = ct_cj;
    sm_we = 1'b0; sm_waddr = sm_lj; sm_wdata = '0; sm_raddr = sm_lj;
    cn_we = 1'b0; cn_waddr = lbl_q; cn_wdata = '0; cn_raddr = lbl_q;
    div_start = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          out_d = '0;
          out_d.done_res = 1'b1;
          rd_di_d  = in_item_i.dim_index;
          rd_pok_d = pt_ok;
          rd_dok_d = dim_ok;
          rd_cok_d = ctr_ok;
          lb_raddr = PT_W'(in_item_i.point_index);
          ct_raddr = CA_W'(CA_W'(in_item_i.label_or_center) * CMD
                           + CA_W'(in_item_i.dim_index));
          cn_raddr = LBL_W'(in_item_i.label_or_center);
          case (in_item_i.mode)
            MODE_LOAD_COORD: begin
              pc_we    = pt_ok && dim_ok;
              pc_waddr = PA_W'(PA_W'(in_item_i.point_index) * PMD
                               + PA_W'(in_item_i.dim_index));
              pc_wdata = COORD_BITS'(in_item_i.value);
              out_valid_d = 1'b1;
            end
            MODE_LOAD_LABEL: begin
              lb_we    = pt_ok;
              lb_waddr = PT_W'(in_item_i.point_index);
              lb_wdata = LS_W'(in_item_i.label_or_center);
              out_valid_d = 1'b1;
            end
            MODE_RUN: begin
              idx_d = '0;
              it_d  = '0;
              state_d = ST_CLR;
            end
            MODE_READ_POINT:  state_d = ST_RD_PT1;
            MODE_READ_CENTER: state_d = ST_RD_CT;
            default: begin
              out_d.done_res = 1'b0;
              out_valid_d = 1'b1;
            end
          endcase
        end
      end
      ST_RD_PT1: begin
        lbl_d    = lbl_clamped;
        ct_raddr = CA_W'(CA_W'(lbl_clamped) * CMD + CA_W'(rd_di_q));
        state_d  = ST_RD_PT2;
      end
      ST_RD_PT2: begin
        out_d.label = rd_pok_q ? LAB_W'(lbl_q) : '0;
        out_d.coord_out = (rd_pok_q && rd_dok_q && ran_q) ?
                          VALUE_W'(signed'(ct_rdata)) : '0;
        out_valid_d = 1'b1;
        state_d = ST_IDLE;
      end
      ST_RD_CT: begin
        out_d.coord_out = (rd_cok_q && rd_dok_q && ran_q) ?
                          VALUE_W'(signed'(ct_rdata)) : '0;
        out_d.member_count = (rd_cok_q && ran_q) ? COUNT_W'(cn_rdata) : '0;
        out_valid_d = 1'b1;
        state_d = ST_IDLE;
      end
      ST_CLR: begin
        sm_we = 1'b1;
        sm_waddr = idx_q[CA_W-1:0];
        cn_we = 32'(idx_q) < MAX_CENTERS;
        cn_waddr = LBL_W'(idx_q);
        idx_d = idx_q + 1'b1;
        if (idx_q == CLR_LAST) begin
          p_d = '0;
          state_d = ST_ACC_L;
        end
      end
      ST_ACC_L: state_d = ST_ACC_LW;
      ST_ACC_LW: begin
        lb_we = 1'b1;
        lb_wdata = LS_W'(lbl_clamped);
        lbl_d = lbl_clamped;
        j_d = '0;
        state_d = ST_ACC_R;
      end
      ST_ACC_R: state_d = ST_ACC_W;
      ST_ACC_W: begin
        sm_we = 1'b1;
        sm_wdata = sm_rdata + {{(SUM_W-COORD_BITS){pc_rdata[COORD_BITS-1]}}, pc_rdata};
        j_d = j_q + 1'b1;
        state_d = (j_q + 1'b1 < d_use) ? ST_ACC_R : ST_CNT_R;
      end
      ST_CNT_R: state_d = ST_CNT_W;
      ST_CNT_W: begin
        cn_we = 1'b1;
        cn_wdata = cn_rdata + 1'b1;
        p_d = p_q + 1'b1;
        if (p_q + 1'b1 < n_use) begin
          state_d = ST_ACC_L;
        end else begin
          c_d = '0;
          j_d = '0;
          state_d = ST_DIV_R;
        end
      end
      ST_DIV_R: begin
        sm_raddr = ct_cj;
        cn_raddr = c_q;
        state_d = ST_DIV_S;
      end
      ST_DIV_S, ST_DIV_W: begin
        if (state_q == ST_DIV_S && cn_rdata != '0) begin
          div_start = 1'b1;
          state_d = ST_DIV_W;
        end else if (state_q == ST_DIV_S || div_done) begin
          ct_we = 1'b1;
          ct_wdata = (state_q == ST_DIV_S) ? '0 : COORD_BITS'(div_q);
          if (32'(j_q) == MAX_DIMS - 1) begin
            j_d = '0;
            c_d = c_q + 1'b1;
            if (32'(c_q) == MAX_CENTERS - 1) begin
              if (it_q < niter_q) begin
                it_d = it_q + 1'b1;
                p_d = '0;
                c_d = '0;
                acc_d = '0;
                state_d = ST_AS_RD;
              end else begin
                state_d = ST_FIN;
              end
            end else begin
              state_d = ST_DIV_R;
            end
          end else begin
            j_d = j_q + 1'b1;
            state_d = ST_DIV_R;
          end
        end
      end
      ST_AS_RD: state_d = ST_AS_DIF;
      ST_AS_DIF: begin
        diff_d = DF_W'(signed'(pc_rdata)) - DF_W'(signed'(ct_rdata));
        state_d = ST_AS_SQ;
      end
      ST_AS_SQ: begin
        sq_d = SQ_W'(diff_q * diff_q);
        state_d = ST_AS_ACC;
      end
      ST_AS_ACC: begin
        if (j_q + 1'b1 < d_use) begin
          acc_d = acc_new;
          j_d = j_q + 1'b1;
          state_d = ST_AS_RD;
        end else begin
          acc_d = '0;
          j_d = '0;
          if (c_q == '0 || acc_new < best_q) begin
            best_d = acc_new;
            best_c_d = c_q;
          end
          if (KW'(c_q) + 1'b1 < k_use) begin
            c_d = c_q + 1'b1;
            state_d = ST_AS_RD;
          end else begin
            lb_we = 1'b1;
            lb_wdata = (c_q == '0 || acc_new < best_q) ? LS_W'(c_q) : LS_W'(best_c_q);
            c_d = '0;
            p_d = p_q + 1'b1;
            if (p_q + 1'b1 < n_use) begin
              state_d = ST_AS_RD;
            end else begin
              idx_d = '0;
              state_d = ST_CLR;
            end
          end
        end
      end
      ST_FIN: begin
        out_valid_d = 1'b1;
        ran_d = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ncent_q     <= NCENT_W'(4);
      niter_q     <= NITER_W'(10);
      npts_q      <= NPTS_W'(1024);
      ndims_q     <= NDIMS_W'(3);
      ran_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ncent_q     <= ncent_d;
      niter_q     <= niter_d;
      npts_q      <= npts_d;
      ndims_q     <= ndims_d;
      ran_q       <= ran_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d; j_q <= j_d; c_q <= c_d; idx_q <= idx_d; it_q <= it_d;
    lbl_q <= lbl_d; best_c_q <= best_c_d; acc_q <= acc_d; best_q <= best_d;
    diff_q <= diff_d; sq_q <= sq_d;
    rd_di_q <= rd_di_d; rd_pok_q <= rd_pok_d; rd_dok_q <= rd_dok_d; rd_cok_q <= rd_cok_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  kml_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_POINTS * MAX_DIMS)) u_pt_coords (
    .clk_i, .we_i(pc_we), .waddr_i(pc_waddr), .wdata_i(pc_wdata),
    .raddr_i(pc_raddr), .rdata_o(pc_rdata)
  );

  kml_ram #(.WIDTH(LS_W), .DEPTH(MAX_POINTS)) u_pt_labels (
    .clk_i, .we_i(lb_we), .waddr_i(lb_waddr), .wdata_i(lb_wdata),
    .raddr_i(lb_raddr), .rdata_o(lb_rdata)
  );

  kml_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_CENTERS * MAX_DIMS)) u_ct_coords (
    .clk_i, .we_i(ct_we), .waddr_i(ct_waddr), .wdata_i(ct_wdata),
    .raddr_i(ct_raddr), .rdata_o(ct_rdata)
  );

  kml_ram #(.WIDTH(SUM_W), .DEPTH(MAX_CENTERS * MAX_DIMS)) u_ct_sums (
    .clk_i, .we_i(sm_we), .waddr_i(sm_waddr), .wdata_i(sm_wdata),
    .raddr_i(sm_raddr), .rdata_o(sm_rdata)
  );

  kml_ram #(.WIDTH(CNT_W), .DEPTH(MAX_CENTERS)) u_ct_counts (
    .clk_i, .we_i(cn_we), .waddr_i(cn_waddr), .wdata_i(cn_wdata),
    .raddr_i(cn_raddr), .rdata_o(cn_rdata)
  );

  kml_div #(.SUM_W(SUM_W), .CNT_W(CNT_W)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(signed'(sm_rdata)),
    .divisor_i(cn_rdata), .done_o(div_done), .quotient_o(div_q)
  );

endmodule
`default_nettype wire
